>>> rtl/core/asf_pkg.sv
// Shared types and constants for the audio sample FIFO.
// No dependencies; imported by asf_ctrl and the top level of the block.
`timescale 1ns / 1ps
`default_nettype none

package asf_pkg;

    localparam int CMD_W      = 2;
    localparam int SMP_W      = 16;
    localparam int CNT_W      = 18;
    localparam int IN_DATA_W  = 40;   // 35 payload bits padded to whole bytes
    localparam int OUT_DATA_W = 40;   // 38 payload bits padded to whole bytes

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SKIP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PAUSE = 2'd3;

    // config register indexes
    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_PREFILL  = 1'b1;

    localparam logic [CNT_W-1:0] CAP_RESET     = 18'd131072;
    localparam logic [CNT_W-1:0] PREFILL_RESET = 18'd2048;

    // status side of one result beat (sample comes from the RAM)
    typedef struct packed {
        logic [CNT_W-1:0] level;
        logic             from_queue;
        logic             starving;
        logic             dropped_oldest;
        logic             playing;
    } t_rsp;

endpackage

`default_nettype wire

>>> rtl/core/asf_ram.sv
// Sample store: single write port, single registered read port.
// Uses asf_pkg for nothing; generic synchronous RAM.
`timescale 1ns / 1ps
`default_nettype none

module asf_ram #(
    parameter int DEPTH = 131072,
    parameter int W     = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [W-1:0]             i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [W-1:0]             o_rd_data
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/core/asf_ctrl.sv
// Pointer, level and prefill/pause control of the sample FIFO.
// Depends on asf_pkg; drives the ports of asf_ram.
`timescale 1ns / 1ps
`default_nettype none

module asf_ctrl
    import asf_pkg::*;
#(
    parameter int DEPTH = 131072
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_idx,
    input  wire logic [CNT_W-1:0]         i_cfg_wdata,
    input  wire logic                     i_go,
    input  wire logic [CMD_W-1:0]         i_cmd,
    input  wire logic [SMP_W-1:0]         i_sample,
    input  wire logic [CNT_W-1:0]         i_skip,
    input  wire logic                     i_pause,
    output logic                          o_wr_en,
    output logic      [$clog2(DEPTH)-1:0] o_wr_addr,
    output logic      [SMP_W-1:0]         o_wr_data,
    output logic                          o_rd_en,
    output logic      [$clog2(DEPTH)-1:0] o_rd_addr,
    output t_rsp                          o_rsp
);

    localparam int PW = $clog2(DEPTH);
    localparam int AW = ((PW > CNT_W) ? PW : CNT_W) + 1;

    function automatic logic [AW-1:0] eff_cap(input logic [CNT_W-1:0] v);
        logic [AW-1:0] e;
        e = AW'(v);
        if (v == '0) begin
            e = AW'(1);
        end else if (e > AW'(DEPTH)) begin
            e = AW'(DEPTH);
        end
        return e;
    endfunction

    // one wrap is enough: pointer < cap and step <= cap
    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                              input logic [AW-1:0] n,
                                              input logic [AW-1:0] cap);
        logic [AW-1:0] q;
        q = AW'(p) + n;
        if (q >= cap) begin
            q = q - cap;
        end
        return q[PW-1:0];
    endfunction

    logic [AW-1:0]    r_cap, n_cap;
    logic [CNT_W-1:0] r_thr, n_thr;
    logic [PW-1:0]    r_head, n_head;
    logic [PW-1:0]    r_tail, n_tail;
    logic [CNT_W-1:0] r_level, n_level;
    logic             r_await, n_await;
    logic             r_paused, n_paused;
    t_rsp             r_rsp, n_rsp;

    logic             full;
    logic [CNT_W-1:0] skip_n;

    always_comb begin
        n_cap    = r_cap;
        n_thr    = r_thr;
        n_head   = r_head;
        n_tail   = r_tail;
        n_level  = r_level;
        n_await  = r_await;
        n_paused = r_paused;
        n_rsp    = r_rsp;
        o_wr_en  = 1'b0;
        o_rd_en  = 1'b0;
        full     = AW'(r_level) >= r_cap;
        skip_n   = (i_skip < r_level) ? i_skip : r_level;

        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_CAPACITY) begin
                n_cap   = eff_cap(i_cfg_wdata);
                n_head  = '0;
                n_tail  = '0;
                n_level = '0;
                n_await = 1'b1;
            end else begin
                n_thr = i_cfg_wdata;
            end
        end

        if (i_go) begin
            n_rsp.from_queue     = 1'b0;
            n_rsp.starving       = 1'b0;
            n_rsp.dropped_oldest = 1'b0;
            case (i_cmd)
                CMD_PUSH: begin
                    o_wr_en = 1'b1;
                    n_tail  = advance(r_tail, AW'(1), r_cap);
                    if (full) begin
                        n_head               = advance(r_head, AW'(1), r_cap);
                        n_rsp.dropped_oldest = 1'b1;
                    end else begin
                        n_level = r_level + CNT_W'(1);
                    end
                    if (r_await && n_level >= r_thr) begin
                        n_await = 1'b0;
                    end
                end
                CMD_READ: begin
                    if (!r_paused) begin
                        if (r_level == '0) begin
                            n_rsp.starving = 1'b1;
                        end else begin
                            o_rd_en          = 1'b1;
                            n_head           = advance(r_head, AW'(1), r_cap);
                            n_level          = r_level - CNT_W'(1);
                            n_rsp.from_queue = 1'b1;
                        end
                    end
                end
                CMD_SKIP: begin
                    n_head  = advance(r_head, AW'(skip_n), r_cap);
                    n_level = r_level - skip_n;
                end
                CMD_PAUSE: begin
                    if (r_paused != i_pause) begin
                        n_head   = '0;
                        n_tail   = '0;
                        n_level  = '0;
                        n_await  = 1'b1;
                        n_paused = i_pause;
                    end
                end
                default: begin
                end
            endcase
            n_rsp.level   = n_level;
            n_rsp.playing = !n_await && !n_paused;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= eff_cap(CAP_RESET);
            r_thr    <= PREFILL_RESET;
            r_head   <= '0;
            r_tail   <= '0;
            r_level  <= '0;
            r_await  <= 1'b1;
            r_paused <= 1'b0;
            r_rsp    <= '0;
        end else begin
            r_cap    <= n_cap;
            r_thr    <= n_thr;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_level  <= n_level;
            r_await  <= n_await;
            r_paused <= n_paused;
            r_rsp    <= n_rsp;
        end
    end

    assign o_wr_addr = r_tail;
    assign o_wr_data = i_sample;
    assign o_rd_addr = r_head;
    assign o_rsp     = r_rsp;

endmodule

`default_nettype wire

>>> rtl/core/audio_sample_fifo_unit.sv
// Top level of the audio sample FIFO: stream handshake and result register.
// Depends on asf_pkg, asf_ctrl and asf_ram.
//
//  channel  | dir | beat contents
//  ---------+-----+---------------------------------------------------------
//  s_*      | in  | tuser: command; tdata: sample, skip_count, pause
//  m_*      | out | tdata: sample_out, from_queue, starving, dropped_oldest,
//           |     |        level, playing
//  i_cfg_*  | in  | index 0 capacity, index 1 prefill_threshold (no read-back)
//
// For every command, pointers, level and flags update at the edge that
// accepts the beat, and a read launches the RAM access at that same edge.
// The result beat is valid the next cycle; a new beat is taken every cycle as
// long as the result register is empty or being drained (rate 1).
// Reset clears pointers, level and flags; the sample RAM is not cleared, since
// only slots written since the last clear are ever read back.
// A push and a read never touch the RAM in the same cycle, so no forwarding.
`timescale 1ns / 1ps
`default_nettype none

module audio_sample_fifo_unit
    import asf_pkg::*;
#(
    parameter int DEPTH = 131072
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write port
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [CNT_W-1:0]      i_cfg_wdata,
    // command stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] sample, [33:16] skip_count,
                                                  // [34] pause, [39:35] zero
    input  wire logic [CMD_W-1:0]      s_tuser,   // [1:0] command
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata    // [15:0] sample_out, [16] from_queue,
                                                  // [17] starving, [18] dropped_oldest,
                                                  // [36:19] level, [37] playing, [39:38] 0
);

    localparam int PW = $clog2(DEPTH);

    logic             go;
    logic             r_m_tvalid;
    logic             wr_en;
    logic [PW-1:0]    wr_addr;
    logic [SMP_W-1:0] wr_data;
    logic             rd_en;
    logic [PW-1:0]    rd_addr;
    logic [SMP_W-1:0] rd_data;
    t_rsp             rsp;
    logic [SMP_W-1:0] sample_out;

    // result register frees up in the same cycle it is drained
    assign s_tready = !r_m_tvalid || m_tready;
    assign go       = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (go) begin
            r_m_tvalid <= 1'b1;
        end else if (m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    asf_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_go       (go),
        .i_cmd      (s_tuser),
        .i_sample   (s_tdata[15:0]),
        .i_skip     (s_tdata[33:16]),
        .i_pause    (s_tdata[34]),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_rsp      (rsp)
    );

    asf_ram #(
        .DEPTH(DEPTH),
        .W    (SMP_W)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // RAM output holds until the next read, so it is stable while stalled
    assign sample_out = rsp.from_queue ? rd_data : '0;

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = {2'b00, rsp.playing, rsp.level, rsp.dropped_oldest,
                       rsp.starving, rsp.from_queue, sample_out};

endmodule

`default_nettype wire
